FILE: design/i2a_pkg.sv
// i2a_pkg: shared types, codes and character constants for the integer to
// ASCII formatter. No dependencies.
package i2a_pkg;

  typedef enum logic [2:0] {
    CMD_SDEC = 3'd0,
    CMD_UDEC = 3'd1,
    CMD_HEXL = 3'd2,
    CMD_HEXU = 3'd3,
    CMD_PTR  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_PREFIX,
    ST_ZEROS,
    ST_DIGITS
  } state_e;

  // Control from the sequencer to the digit register
  typedef struct packed {
    logic load_hex;
    logic load_dec;
    logic shift_digit;
  } dig_ctrl_t;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_X     = 8'h78;  // 'x'
  localparam logic [7:0] CHAR_MINUS = 8'h2d;  // '-'
  localparam logic [3:0] DIGIT_TEN  = 4'ha;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CHAR_UA : CHAR_LA;
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + {4'b0, d};
    end
    return base + {4'b0, d - DIGIT_TEN};
  endfunction

endpackage

FILE: design/i2a_digits.sv
// i2a_digits: digit shift register. Loads hex nibbles directly or builds BCD
// digits from the binary value one bit per cycle (shift and add 3).
// Depends on i2a_pkg.
module i2a_digits #(
  parameter int NDIG = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2a_pkg::dig_ctrl_t   ctrl_i,
  input  logic [63:0]          value_i,
  output logic [3:0]           top_o,
  output logic                 busy_o
);

  localparam int DW = NDIG * 4;

  logic [DW-1:0] dig_q, dig_d, adj;
  logic [63:0]   bin_q, bin_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3
                                                 : dig_q[4*i +: 4];
    end
  end

  always_comb begin
    dig_d  = dig_q;
    bin_d  = bin_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (ctrl_i.load_dec) begin
      dig_d  = '0;
      bin_d  = value_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (ctrl_i.load_hex) begin
      dig_d  = DW'(value_i);
      busy_d = 1'b0;
    end else if (busy_q) begin
      dig_d = {adj[DW-2:0], bin_q[63]};
      bin_d = {bin_q[62:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
      end
    end else if (ctrl_i.shift_digit) begin
      dig_d = {dig_q[DW-5:0], 4'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    bin_q <= bin_d;
  end

  assign top_o  = dig_q[DW-1 -: 4];
  assign busy_o = busy_q;

endmodule

FILE: design/integer_to_ascii_formatter_top.sv
// integer_to_ascii_formatter_top: formats a 64-bit value as signed/unsigned
// decimal, hex or pointer ASCII text. Depends on i2a_pkg and i2a_digits.
//
// One number is handled at a time; in_stall_o stays high until its last
// character has been loaded into the output register. Decimal goes through
// bit-serial BCD conversion in the digit register, hex loads directly. Then
// leading zero digits are stripped, and the characters (sign or "0x", pad
// zeros, digits) leave at most one per cycle while out_stall_i is low.
// Commands above pointer are accepted and produce no output.
module integer_to_ascii_formatter_top #(
  parameter int MAX_DIGITS = 20,
  parameter int MAX_PAD    = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [63:0] value_i,
  input  logic [5:0]  pad_width_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_out_o,
  output logic        last_o
);

  localparam int NW = $clog2(MAX_DIGITS + 1);

  i2a_pkg::state_e    state_q, state_d;
  i2a_pkg::dig_ctrl_t dctrl;
  logic [63:0] dig_value;
  logic [3:0]  top_dig;
  logic        dig_busy;

  logic          upper_q, upper_d;
  logic [15:0]   pre_q, pre_d;
  logic [1:0]    pre_n_q, pre_n_d;
  logic [5:0]    pad_q, pad_d;
  logic [NW-1:0] nd_q, nd_d;
  logic [5:0]    zeros_q, zeros_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q, out_char_d;
  logic          out_last_q, out_last_d;

  logic       out_free, in_acc, neg;
  logic [6:0] total;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && (state_q == i2a_pkg::ST_IDLE);
  assign neg      = (command_i == i2a_pkg::CMD_SDEC) && value_i[63];
  assign dig_value = neg ? (64'd0 - value_i) : value_i;
  assign total    = 7'(nd_q) + 7'(pre_n_q);

  always_comb begin
    state_d     = state_q;
    upper_d     = upper_q;
    pre_d       = pre_q;
    pre_n_d     = pre_n_q;
    pad_d       = pad_q;
    nd_d        = nd_q;
    zeros_d     = zeros_q;
    dctrl       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    case (state_q)
      i2a_pkg::ST_IDLE: begin
        if (in_acc && (command_i <= i2a_pkg::CMD_PTR)) begin
          pad_d   = (pad_width_i > 6'(MAX_PAD)) ? 6'(MAX_PAD) : pad_width_i;
          upper_d = (command_i == i2a_pkg::CMD_HEXU);
          nd_d    = NW'(MAX_DIGITS);
          pre_n_d = 2'd0;
          pre_d   = '0;
          if (neg) begin
            pre_d   = {i2a_pkg::CHAR_MINUS, 8'h00};
            pre_n_d = 2'd1;
          end else if ((command_i == i2a_pkg::CMD_PTR) && (value_i != 64'd0)) begin
            pre_d   = {i2a_pkg::CHAR_ZERO, i2a_pkg::CHAR_X};
            pre_n_d = 2'd2;
          end
          if ((command_i == i2a_pkg::CMD_SDEC) || (command_i == i2a_pkg::CMD_UDEC)) begin
            dctrl.load_dec = 1'b1;
          end else begin
            dctrl.load_hex = 1'b1;
          end
          state_d = i2a_pkg::ST_CONV;
        end
      end
      i2a_pkg::ST_CONV: begin
        if (!dig_busy) begin
          state_d = i2a_pkg::ST_NORM;
        end
      end
      i2a_pkg::ST_NORM: begin
        if ((nd_q > NW'(1)) && (top_dig == 4'd0)) begin
          dctrl.shift_digit = 1'b1;
          nd_d = nd_q - NW'(1);
        end else begin
          zeros_d = ({1'b0, pad_q} > total) ? 6'({1'b0, pad_q} - total) : 6'd0;
          state_d = i2a_pkg::ST_PREFIX;
        end
      end
      i2a_pkg::ST_PREFIX: begin
        if (pre_n_q == 2'd0) begin
          state_d = i2a_pkg::ST_ZEROS;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = pre_q[15:8];
          out_last_d  = 1'b0;
          pre_d       = {pre_q[7:0], 8'h00};
          pre_n_d     = pre_n_q - 2'd1;
        end
      end
      i2a_pkg::ST_ZEROS: begin
        if (zeros_q == 6'd0) begin
          state_d = i2a_pkg::ST_DIGITS;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = i2a_pkg::CHAR_ZERO;
          out_last_d  = 1'b0;
          zeros_d     = zeros_q - 6'd1;
        end
      end
      i2a_pkg::ST_DIGITS: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_char_d        = i2a_pkg::digit_char(top_dig, upper_q);
          out_last_d        = (nd_q == NW'(1));
          dctrl.shift_digit = 1'b1;
          nd_d              = nd_q - NW'(1);
          if (nd_q == NW'(1)) begin
            state_d = i2a_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = i2a_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i2a_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    upper_q    <= upper_d;
    pre_q      <= pre_d;
    pre_n_q    <= pre_n_d;
    pad_q      <= pad_d;
    nd_q       <= nd_d;
    zeros_q    <= zeros_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  i2a_digits #(
    .NDIG (MAX_DIGITS)
  ) u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (dctrl),
    .value_i (dig_value),
    .top_o   (top_dig),
    .busy_o  (dig_busy)
  );

  assign in_stall_o  = (state_q != i2a_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign char_out_o  = out_char_q;
  assign last_o      = out_last_q;

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking testbench for integer_to_ascii_formatter_top.
// Predicts each formatted character in the testbench itself and compares it
// with the output. Depends on i2a_pkg and the formatter RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 200;
  localparam int HOLD_OFF_CYCLES = 400;

  // Command codes the block accepts but ignores
  localparam logic [2:0] CMD_UNUSED5 = 3'd5;
  localparam logic [2:0] CMD_UNUSED6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED7 = 3'd7;

  localparam logic [63:0] VAL_ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] VAL_MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VAL_MOST_POS = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  command_i;
  logic [63:0] value_i;
  logic [5:0]  pad_width_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  char_out_o;
  logic        last_o;

  text_char_t  pending_text[$];
  int          error_count;
  int          cycle_count;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int          rx_hold_cycles;
  int          rx_wait_cycles;
  bit          char_taken;

  integer_to_ascii_formatter_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .pad_width_i(pad_width_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .char_out_o (char_out_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Appends the characters one number should produce to pending_text
  function automatic void predict_text(input logic [2:0] cmd, input logic [63:0] val,
                                       input logic [5:0] pad_in);
    logic [7:0]  text[$];
    logic [7:0]  digs[$];
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] rem;
    logic [7:0]  alpha;
    int          pad;
    text_char_t  tc;
    if (cmd > i2a_pkg::CMD_PTR) return;
    mag   = val;
    pad   = int'(pad_in);
    radix = 64'd10;
    alpha = i2a_pkg::CHAR_LA;
    case (i2a_pkg::cmd_e'(cmd))
      i2a_pkg::CMD_SDEC: begin
        if (val[63]) begin
          text.push_back(i2a_pkg::CHAR_MINUS);
          mag = 64'd0 - val;
          pad--;
        end
      end
      i2a_pkg::CMD_HEXL: radix = 64'd16;
      i2a_pkg::CMD_HEXU: begin
        radix = 64'd16;
        alpha = i2a_pkg::CHAR_UA;
      end
      i2a_pkg::CMD_PTR: begin
        radix = 64'd16;
        if (val != 64'd0) begin
          text.push_back(i2a_pkg::CHAR_ZERO);
          text.push_back(i2a_pkg::CHAR_X);
          pad -= 2;
        end
      end
      default: ;
    endcase
    do begin
      rem = mag % radix;
      if (rem < 64'(i2a_pkg::DIGIT_TEN)) digs.push_front(i2a_pkg::CHAR_ZERO + rem[7:0]);
      else digs.push_front(alpha + rem[7:0] - 8'(i2a_pkg::DIGIT_TEN));
      mag = mag / radix;
    end while (mag != 64'd0);
    while (digs.size() < pad) begin
      text.push_back(i2a_pkg::CHAR_ZERO);
      pad--;
    end
    foreach (digs[i]) text.push_back(digs[i]);
    foreach (text[i]) begin
      tc.ch   = text[i];
      tc.last = (i == text.size() - 1);
      pending_text.push_back(tc);
    end
  endfunction

  // Entered and left at a falling edge
  task automatic send_number(input logic [2:0] cmd, input logic [63:0] val,
                             input logic [5:0] pad);
    int gap;
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    value_i     <= val;
    pad_width_i <= pad;
    do @(posedge clk_i); while (in_stall_o);
    predict_text(cmd, val, pad);
    @(negedge clk_i);
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_all_chars();
    in_valid_i <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1: v = v >> $urandom_range(0, 63);
      2:    v = 64'($urandom_range(0, 20));
      3:    v = ~(v >> $urandom_range(1, 63));  // negative
      4: begin
        case ($urandom_range(0, 5))
          0: v = 64'd0;
          1: v = VAL_ALL_ONES;
          2: v = VAL_MOST_NEG;
          3: v = VAL_MOST_POS;
          4: v = 64'd9999999999999999999;
          default: v = 64'd10000000000000000000;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] rand_pad();
    if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 24));
  endfunction

  task automatic send_random(input int valid_items);
    logic [2:0] cmd;
    int         sent;
    sent = 0;
    while (sent < valid_items) begin
      if ($urandom_range(0, 9) == 0) cmd = 3'($urandom_range(CMD_UNUSED5, CMD_UNUSED7));
      else cmd = 3'($urandom_range(i2a_pkg::CMD_SDEC, i2a_pkg::CMD_PTR));
      send_number(cmd, rand_value(), rand_pad());
      if (cmd <= i2a_pkg::CMD_PTR) sent++;
    end
  endtask

  task automatic test_corner_numbers();
    send_number(i2a_pkg::CMD_SDEC, 64'd0, 6'd0);
    send_number(i2a_pkg::CMD_SDEC, VAL_MOST_NEG, 6'd0);
    send_number(i2a_pkg::CMD_SDEC, VAL_MOST_NEG, 6'd63);
    send_number(i2a_pkg::CMD_SDEC, VAL_MOST_POS, 6'd0);
    send_number(i2a_pkg::CMD_SDEC, VAL_ALL_ONES, 6'd5);
    send_number(i2a_pkg::CMD_SDEC, 64'd0 - 64'd12345, 6'd6);
    send_number(i2a_pkg::CMD_UDEC, VAL_ALL_ONES, 6'd0);
    send_number(i2a_pkg::CMD_UDEC, 64'd0, 6'd63);
    send_number(i2a_pkg::CMD_UDEC, 64'd12345, 6'd2);
    send_number(i2a_pkg::CMD_UDEC, 64'd10000000000000000000, 6'd21);
    send_number(i2a_pkg::CMD_HEXL, 64'd0, 6'd0);
    send_number(i2a_pkg::CMD_HEXL, VAL_ALL_ONES, 6'd0);
    send_number(i2a_pkg::CMD_HEXL, 64'h0123_4567_89ab_cdef, 6'd3);
    send_number(i2a_pkg::CMD_HEXU, 64'hfedc_ba98_7654_3210, 6'd20);
    send_number(i2a_pkg::CMD_HEXU, 64'h0000_0000_00ab_cdef, 6'd63);
    send_number(i2a_pkg::CMD_PTR, 64'd0, 6'd0);
    send_number(i2a_pkg::CMD_PTR, 64'd0, 6'd63);
    send_number(i2a_pkg::CMD_PTR, 64'd1, 6'd1);
    send_number(i2a_pkg::CMD_PTR, VAL_ALL_ONES, 6'd63);
    send_number(i2a_pkg::CMD_PTR, 64'h0000_0000_dead_beef, 6'd10);
    send_number(CMD_UNUSED5, VAL_ALL_ONES, 6'd63);
    send_number(CMD_UNUSED6, 64'd0, 6'd0);
    send_number(CMD_UNUSED7, 64'd42, 6'd7);
  endtask

  task automatic test_random_with_gaps();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_random(250);
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(80);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Receiver holds off while numbers keep coming, so the input stalls
  task automatic test_output_hold_off();
    rx_hold_cycles = HOLD_OFF_CYCLES;
    send_random(30);
  endtask

  // Sender stops until every character is out, then resumes
  task automatic test_drain_pause();
    send_random(15);
    wait_all_chars();
    send_random(15);
  endtask

  // Output stall: random wait per character, plus an optional long hold-off
  initial begin
    out_stall_i    = 1'b0;
    rx_hold_cycles = 0;
    rx_wait_cycles = 0;
    char_taken     = 1'b0;
    forever begin
      @(negedge clk_i);
      if (char_taken) begin
        rx_wait_cycles = rx_idle_on ? $urandom_range(0, 3) : 0;
        char_taken     = 1'b0;
      end
      if (rx_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        rx_hold_cycles--;
      end else if (rx_wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        rx_wait_cycles--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      char_taken = 1'b1;
      if (pending_text.size() == 0) begin
        $error("unexpected transaction: char_out=%h last=%b", char_out_o, last_o);
        error_count++;
      end else begin
        want = pending_text.pop_front();
        if (char_out_o !== want.ch) begin
          $error("char_out mismatch: expected %h actual %h", want.ch, char_out_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last mismatch: expected %b actual %b", want.last, last_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("integer_to_ascii_formatter_top verification failed");
    $finish;
  end

  initial begin
    error_count = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    command_i   = i2a_pkg::CMD_SDEC;
    value_i     = 64'd0;
    pad_width_i = 6'd0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_corner_numbers();
    test_random_with_gaps();
    test_back_to_back();
    test_output_hold_off();
    test_drain_pause();
    wait_all_chars();

    if (pending_text.size() != 0) begin
      $error("%0d expected characters never arrived", pending_text.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("integer_to_ascii_formatter_top verification clean");
    end else begin
      $display("integer_to_ascii_formatter_top verification failed");
    end
    $finish;
  end

endmodule
